// File: rtl/core/utf8_sanitizer_replace_invalid_assert.svh
// assertion helpers included by u8s_back of the sanitizer rtl
`ifndef UTF8_SANITIZER_REPLACE_INVALID_ASSERT_SVH
`define UTF8_SANITIZER_REPLACE_INVALID_ASSERT_SVH
`ifndef ASSERT_OFF
// antecedent in a cycle implies consequent in the same cycle
`define U8S_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// antecedent in a cycle implies consequent in the next cycle
`define U8S_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define U8S_ASSERT_IMPL(lbl, ante, cons, msg)
`define U8S_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/core/u8s_pkg.sv
`default_nettype none
package u8s_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  // byte class as seen at a lead position
  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_INVALID
  } cls_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    cls_t       cls;
  } qent_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

// File: rtl/core/u8s_if.sv
`default_nettype none
interface u8s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       message_last;

  modport source (output valid, output in_byte, output message_last, input ready);
  modport sink (input valid, input in_byte, input message_last, output ready);
endinterface

interface u8s_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       message_end;

  modport source (output valid, output out_byte, output run_end, output message_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_end, input message_end,
                output ready);
endinterface
`default_nettype wire

// File: rtl/core/u8s_fifo.sv
`default_nettype none
module u8s_fifo #(
  parameter int DEPTH = u8s_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  u8s_pkg::qent_t push_data,
  output logic           full,
  input  logic           pop,
  output u8s_pkg::qent_t pop_data,
  output logic           empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u8s_pkg::qent_t mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/u8s_front.sv
`default_nettype none
module u8s_front #(
  parameter int DEPTH = u8s_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  u8s_in_if.sink         inbound,
  input  logic           q_pop,
  output u8s_pkg::qent_t q_data,
  output logic           q_avail
);

  function automatic u8s_pkg::cls_t classify(input logic [7:0] b);
    u8s_pkg::cls_t c;
    if (!b[7]) begin
      c = u8s_pkg::CLS_ASCII;
    end else if ((b & 8'hE0) == 8'hC0) begin
      c = u8s_pkg::CLS_LEAD2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      c = u8s_pkg::CLS_LEAD3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      c = u8s_pkg::CLS_LEAD4;
    end else begin
      c = u8s_pkg::CLS_INVALID;
    end
    return c;
  endfunction

  logic           full;
  logic           empty;
  logic           push;
  u8s_pkg::qent_t push_data;

  assign inbound.ready  = !full;
  assign push           = inbound.valid && !full;
  assign push_data.data = inbound.in_byte;
  assign push_data.last = inbound.message_last;
  assign push_data.cls  = classify(inbound.in_byte);
  assign q_avail        = !empty;

  u8s_fifo #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (empty)
  );

endmodule
`default_nettype wire

// File: rtl/core/u8s_back.sv
`default_nettype none
`include "utf8_sanitizer_replace_invalid_assert.svh"
module u8s_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_avail,
  input  u8s_pkg::qent_t q_data,
  output logic           q_pop,
  u8s_out_if.source      outbound
);

  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  function automatic logic [2:0] cls_need(input u8s_pkg::cls_t c);
    logic [2:0] n;
    unique case (c)
      u8s_pkg::CLS_LEAD2: n = 3'd2;
      u8s_pkg::CLS_LEAD3: n = 3'd3;
      u8s_pkg::CLS_LEAD4: n = 3'd4;
      default:            n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic seq_ok(input logic [7:0] b0, input logic [7:0] b1,
                                  input logic [7:0] b2, input logic [7:0] b3,
                                  input logic [2:0] need);
    logic [20:0] cp;
    logic        c1;
    logic        c2;
    logic        c3;
    logic        ok;
    c1 = (b1[7:6] == 2'b10);
    c2 = (b2[7:6] == 2'b10);
    c3 = (b3[7:6] == 2'b10);
    case (need)
      3'd2: begin
        cp = {10'd0, b0[4:0], b1[5:0]};
        ok = c1 && (cp >= 21'h80);
      end
      3'd3: begin
        cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
        ok = c1 && c2 && (cp >= 21'h800) && !((cp >= 21'hD800) && (cp <= 21'hDFFF));
      end
      3'd4: begin
        cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        ok = c1 && c2 && c3 && (cp >= 21'h10000) && (cp <= 21'h10FFFF);
      end
      default: begin
        cp = '0;
        ok = 1'b0;
      end
    endcase
    return ok;
  endfunction

  u8s_pkg::state_t state;
  u8s_pkg::state_t state_next;

  // scan window: held bytes plus the newest one
  logic [7:0]      win [4];
  u8s_pkg::cls_t   win_cls [4];
  logic [2:0]      win_cnt;
  logic            win_last;

  // bytes of the action being sent
  logic [7:0]      ebuf [4];
  logic [2:0]      e_len;
  logic [1:0]      e_idx;
  logic            e_done;

  logic            o_valid;
  logic [7:0]      o_byte;
  logic            o_run;
  logic            o_msg;

  // scan decision
  logic [2:0]      need0;
  logic            is_ascii;
  logic            hold;
  logic            take_seq;
  logic [2:0]      consume;
  logic [2:0]      rem;
  logic [7:0]      sh [4];
  u8s_pkg::cls_t   sh_cls [4];
  logic [2:0]      need_after;
  logic            done;

  logic            out_free;
  logic            emit_fire;
  logic            last_emit;

  always_comb begin
    logic [2:0] idx;
    idx      = '0;
    need0    = cls_need(win_cls[0]);
    is_ascii = (win_cls[0] == u8s_pkg::CLS_ASCII);
    hold     = (need0 != 3'd0) && (need0 > win_cnt) && !win_last;
    take_seq = is_ascii ||
               ((need0 != 3'd0) && (need0 <= win_cnt) &&
                seq_ok(win[0], win[1], win[2], win[3], need0));
    consume  = is_ascii ? 3'd1 : (take_seq ? need0 : 3'd1);
    rem      = win_cnt - consume;
    for (int i = 0; i < 4; i++) begin
      idx = 3'(i) + consume;
      if (idx < 3'd4) begin
        sh[i]     = win[idx[1:0]];
        sh_cls[i] = win_cls[idx[1:0]];
      end else begin
        sh[i]     = win[i];
        sh_cls[i] = win_cls[i];
      end
    end
    // the item is finished once nothing is left or the rest must wait
    need_after = cls_need(sh_cls[0]);
    done = (rem == 3'd0) ||
           (!win_last && (need_after != 3'd0) && (need_after > rem));
  end

  assign out_free  = !o_valid || outbound.ready;
  assign last_emit = ({1'b0, e_idx} == (e_len - 3'd1));

  always_comb begin
    state_next = state;
    unique case (state)
      u8s_pkg::ST_IDLE: begin
        if (q_avail) begin
          state_next = u8s_pkg::ST_SCAN;
        end
      end
      u8s_pkg::ST_SCAN: begin
        state_next = hold ? u8s_pkg::ST_IDLE : u8s_pkg::ST_EMIT;
      end
      u8s_pkg::ST_EMIT: begin
        if (out_free && last_emit) begin
          state_next = e_done ? u8s_pkg::ST_IDLE : u8s_pkg::ST_SCAN;
        end
      end
      default: state_next = u8s_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    emit_fire = 1'b0;
    unique case (state)
      u8s_pkg::ST_IDLE: q_pop     = q_avail;
      u8s_pkg::ST_SCAN: q_pop     = 1'b0;
      u8s_pkg::ST_EMIT: emit_fire = out_free;
      default: begin
        q_pop     = 1'b0;
        emit_fire = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= u8s_pkg::ST_IDLE;
      win_cnt  <= '0;
      win_last <= 1'b0;
      o_valid  <= 1'b0;
      e_idx    <= '0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        win[win_cnt[1:0]]     <= q_data.data;
        win_cls[win_cnt[1:0]] <= q_data.cls;
        win_cnt               <= win_cnt + 3'd1;
        win_last              <= q_data.last;
      end
      if ((state == u8s_pkg::ST_SCAN) && !hold) begin
        win     <= sh;
        win_cls <= sh_cls;
        win_cnt <= rem;
        e_idx   <= '0;
        e_done  <= done;
        if (take_seq) begin
          ebuf  <= win;
          e_len <= consume;
        end else begin
          ebuf[0] <= REPL_B0;
          ebuf[1] <= REPL_B1;
          ebuf[2] <= REPL_B2;
          ebuf[3] <= REPL_B2;
          e_len   <= 3'd3;
        end
      end
      if (emit_fire) begin
        o_valid <= 1'b1;
        o_byte  <= ebuf[e_idx];
        o_run   <= last_emit && e_done;
        o_msg   <= last_emit && e_done && win_last;
        e_idx   <= e_idx + 2'd1;
      end else if (outbound.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  assign outbound.valid       = o_valid;
  assign outbound.out_byte    = o_byte;
  assign outbound.run_end     = o_run;
  assign outbound.message_end = o_msg;

  `U8S_ASSERT_IMPL(a_idle_room, state == u8s_pkg::ST_IDLE, win_cnt <= 3'd3, "window overfull while idle")
  `U8S_ASSERT_IMPL(a_held_not_last, (state == u8s_pkg::ST_IDLE) && (win_cnt != 3'd0), !win_last, "bytes held past end of message")
  `U8S_ASSERT_IMPL(a_msg_ends_run, o_valid && o_msg, o_run, "message end without run end")
  `U8S_ASSERT_NEXT(a_msg_flushes, emit_fire && last_emit && e_done && win_last, (state == u8s_pkg::ST_IDLE) && (win_cnt == 3'd0), "store not empty after message end")

endmodule
`default_nettype wire

// File: rtl/core/utf8_sanitizer_replace_invalid.sv
`default_nettype none
// utf8 sanitizer: passes well-formed utf-8 through and puts EF BF BD in place
// of the lead byte of each rejected sequence
// inbound: one raw byte per item with message_last marking the message end
// outbound: one output byte per item; run_end flags the last byte caused by
// an input item, message_end the final byte of the message
// a small queue takes input items while the scan engine is busy; the engine
// pops an item when idle, makes a scan decision and then sends the output
// bytes one at a time, and takes no new item until they are sent; a plain
// ascii byte gives one output byte, a byte that completes an n-byte sequence
// gives n and a rejected byte gives the three replacement bytes
// the bytes of an unfinished sequence are held (up to three) and give no
// output until the sequence completes, fails or the message ends
// reset empties the queue, the held bytes and the output register
// when the receiver stalls the output register holds its item, the engine
// waits, and the queue fills before inbound ready drops
module utf8_sanitizer_replace_invalid #(
  parameter int QUEUE_DEPTH = u8s_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  u8s_in_if.sink    inbound,
  u8s_out_if.source outbound
);

  u8s_pkg::qent_t q_data;
  logic           q_avail;
  logic           q_pop;

  u8s_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .inbound (inbound),
    .q_pop   (q_pop),
    .q_data  (q_data),
    .q_avail (q_avail)
  );

  u8s_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_avail  (q_avail),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .outbound (outbound)
  );

endmodule
`default_nettype wire

// File: tb/utf8_sanitizer_replace_invalid_checker.sv
`timescale 1ns / 1ps
module utf8_sanitizer_replace_invalid_checker (
  input  logic        clk,
  input  logic        rst,
  u8s_in_if           inbound,
  u8s_out_if          outbound,
  output int unsigned fail_count,
  output int unsigned expected_left
);

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       message_end;
  } clean_byte_t;

  clean_byte_t sanitized_q[$];
  logic [7:0]  held [3];
  int unsigned held_n;
  logic [7:0]  scan_win [4];

  function automatic int unsigned lead_len(input logic [7:0] c);
    if (c[7:5] == 3'b110) return 2;
    if (c[7:4] == 4'b1110) return 3;
    if (c[7:3] == 5'b11110) return 4;
    return 0;
  endfunction

  // decode scan_win[p +: len] and apply the range, overlong and surrogate rules
  function automatic bit well_formed(input int unsigned p, input int unsigned len);
    logic [20:0] cp;
    case (len)
      2: cp = {16'd0, scan_win[p][4:0]};
      3: cp = {17'd0, scan_win[p][3:0]};
      default: cp = {18'd0, scan_win[p][2:0]};
    endcase
    for (int unsigned k = 1; k < len; k++) begin
      if (scan_win[p + k][7:6] != 2'b10) return 1'b0;
      cp = {cp[14:0], scan_win[p + k][5:0]};
    end
    case (len)
      2: return cp >= 21'h80;
      3: return cp >= 21'h800 && !(cp >= 21'hD800 && cp <= 21'hDFFF);
      default: return cp >= 21'h10000 && cp <= 21'h10FFFF;
    endcase
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    clean_byte_t entry;
    entry = '{data: b, run_end: 1'b0, message_end: 1'b0};
    sanitized_q.insert(sanitized_q.size(), entry);
  endfunction

  function automatic void put_replacement();
    put_byte(8'hEF);
    put_byte(8'hBF);
    put_byte(8'hBD);
  endfunction

  task automatic sanitize_byte(input logic [7:0] b, input logic last);
    int unsigned n;
    int unsigned p;
    int unsigned len;
    int unsigned first;
    first = sanitized_q.size();
    n = held_n;
    for (int unsigned k = 0; k < n; k++) scan_win[k] = held[k];
    scan_win[n] = b;
    n++;
    p = 0;
    while (p < n) begin
      len = lead_len(scan_win[p]);
      if (scan_win[p][7] == 1'b0) begin
        put_byte(scan_win[p]);
        p++;
      end else if (len == 0) begin
        put_replacement();
        p++;
      end else if (p + len > n) begin
        // lead still waiting for its continuation bytes
        if (!last) break;
        put_replacement();
        p++;
      end else if (!well_formed(p, len)) begin
        put_replacement();
        p++;
      end else begin
        for (int unsigned k = 0; k < len; k++) put_byte(scan_win[p + k]);
        p += len;
      end
    end
    held_n = n - p;
    for (int unsigned k = 0; k < held_n; k++) held[k] = scan_win[p + k];
    if (sanitized_q.size() > first) begin
      sanitized_q[sanitized_q.size() - 1].run_end = 1'b1;
      sanitized_q[sanitized_q.size() - 1].message_end = last;
    end
  endtask

  always @(posedge clk) begin
    clean_byte_t want;
    if (rst) begin
      held_n = 0;
      fail_count = 0;
      sanitized_q.delete();
    end else begin
      if (inbound.valid && inbound.ready)
        sanitize_byte(inbound.in_byte, inbound.message_last);
      if (outbound.valid && outbound.ready) begin
        if (sanitized_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected output byte %02h run_end %0b message_end %0b",
                     outbound.out_byte, outbound.run_end, outbound.message_end);
          fail_count++;
        end else begin
          want = sanitized_q.pop_front();
          if (outbound.out_byte !== want.data || outbound.run_end !== want.run_end ||
              outbound.message_end !== want.message_end) begin
            if (fail_count < 10)
              $display("mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                       want.data, want.run_end, want.message_end,
                       outbound.out_byte, outbound.run_end, outbound.message_end);
            fail_count++;
          end
        end
      end
    end
    expected_left = sanitized_q.size();
  end

endmodule

// File: tb/utf8_sanitizer_replace_invalid_tb.sv
`timescale 1ns / 1ps
module utf8_sanitizer_replace_invalid_tb;

  localparam int unsigned RANDOM_ITEMS = 406;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } raw_byte_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        calm;
  int unsigned sent;
  int unsigned quiet_cycles;
  int unsigned fail_count;
  int unsigned expected_left;
  raw_byte_t   message_q[$];

  u8s_in_if  in_ch ();
  u8s_out_if out_ch ();

  utf8_sanitizer_replace_invalid i_dut (
    .clk      (clk),
    .rst      (rst),
    .inbound  (in_ch),
    .outbound (out_ch)
  );

  utf8_sanitizer_replace_invalid_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .inbound       (in_ch),
    .outbound      (out_ch),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  always #1 clk = ~clk;

  task automatic add_byte(input logic [7:0] b, input logic last);
    raw_byte_t entry;
    entry = '{data: b, last: last};
    message_q.insert(message_q.size(), entry);
  endtask

  // one code point: mostly well formed, some overlong, surrogate, too large,
  // corrupted or cut short, plus plain noise and ascii
  task automatic add_random_sequence();
    int unsigned kind;
    int unsigned len;
    logic [20:0] cp;
    logic [20:0] lo;
    logic [20:0] hi;
    logic [7:0]  s [4];
    kind = $urandom_range(99);
    len = 1;
    if (kind < 15) begin
      s[0] = 8'($urandom);
    end else if (kind < 30) begin
      s[0] = 8'($urandom_range(127));
    end else begin
      len = $urandom_range(4, 2);
      case (len)
        2: begin lo = 21'h80; hi = 21'h7FF; end
        3: begin lo = 21'h800; hi = 21'hFFFF; end
        default: begin lo = 21'h10000; hi = 21'h10FFFF; end
      endcase
      if ($urandom_range(3) == 0) cp = $urandom_range(1) ? lo : hi;
      else cp = 21'($urandom_range(hi, lo));
      if (len == 3 && cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h2000;
      if (kind >= 75 && kind < 85) begin
        cp = 21'($urandom_range(lo - 1));
      end else if (kind >= 85 && kind < 92) begin
        if (len == 4) cp = 21'($urandom_range(21'h1FFFFF, 21'h110000));
        else begin
          len = 3;
          cp = 21'($urandom_range(21'hDFFF, 21'hD800));
        end
      end
      case (len)
        2: begin
          s[0] = {3'b110, cp[10:6]};
          s[1] = {2'b10, cp[5:0]};
        end
        3: begin
          s[0] = {4'b1110, cp[15:12]};
          s[1] = {2'b10, cp[11:6]};
          s[2] = {2'b10, cp[5:0]};
        end
        default: begin
          s[0] = {5'b11110, cp[20:18]};
          s[1] = {2'b10, cp[17:12]};
          s[2] = {2'b10, cp[11:6]};
          s[3] = {2'b10, cp[5:0]};
        end
      endcase
      if (kind >= 92) begin
        if ($urandom_range(1)) s[$urandom_range(len - 1, 1)] = 8'($urandom);
        else len = $urandom_range(len - 1, 1);
      end
    end
    for (int unsigned k = 0; k < len; k++)
      add_byte(s[k], k == len - 1 && $urandom_range(9) == 0);
  endtask

  task automatic build_stimulus();
    logic [7:0] directed [24];
    directed = '{8'h00, 8'h7F, 8'hDF, 8'hBF, 8'hC1, 8'hBF, 8'hED, 8'hA0, 8'h80,
                 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hF4, 8'h90, 8'h80, 8'h80, 8'hFF,
                 8'hC3, 8'h41, 8'hF0, 8'hF0, 8'hF0, 8'hF0};
    // three leads held, then a fourth ends the message: four replacements
    foreach (directed[k]) add_byte(directed[k], k == 23);
    while (message_q.size() < 24 + RANDOM_ITEMS) add_random_sequence();
    message_q[message_q.size() - 1].last = 1'b1;
  endtask

  // output side stalls at random except inside the calm window
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || $urandom_range(99) >= 19;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("** utf8_sanitizer_replace_invalid: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    raw_byte_t item;
    bit        done;
    rst = 1'b1;
    calm = 1'b0;
    sent = 0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.message_last = 1'b0;
    build_stimulus();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    done = 1'b0;
    while (!done) begin
      @(posedge clk);
      calm <= sent >= 180 && sent < 280;
      if (!in_ch.valid || in_ch.ready) begin
        if (message_q.size() == 0) begin
          in_ch.valid <= 1'b0;
          done = 1'b1;
        end else if (!calm && $urandom_range(99) < 19) begin
          in_ch.valid <= 1'b0;
        end else begin
          item = message_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.in_byte <= item.data;
          in_ch.message_last <= item.last;
          sent++;
        end
      end
    end
    do @(negedge clk); while (expected_left != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && expected_left == 0) begin
      $display("** utf8_sanitizer_replace_invalid: PASSED **");
    end else begin
      $display("** utf8_sanitizer_replace_invalid: FAILED **");
    end
    $finish;
  end

endmodule
